// File: design/slo_pkg.sv
// Package for the sight-line occlusion step: item types, codes and widths.
`default_nettype none
package slo_pkg;

	// Item codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_LINE  = 1'b1;

	// Shared divider widths
	localparam int DVD_W  = 52;
	localparam int DVS_W  = 36;
	localparam int QUOT_W = 32;
	localparam int CNT_W  = 6;

	// Crossing window on the intersection fraction
	localparam logic [31:0] FRAC_LOW  = 32'd4;
	localparam logic [31:0] FRAC_UNIT = 32'h0001_0000;

	typedef struct packed {
		logic               func;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
		logic               two_sided;
		logic signed [31:0] front_floor;
		logic signed [31:0] front_ceiling;
		logic signed [31:0] back_floor;
		logic signed [31:0] back_ceiling;
	} in_t;

	typedef struct packed {
		logic visible;
		logic crossed;
	} out_t;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_START     = 13'b0000000000010,
		S_MUL       = 13'b0000000000100,
		S_SUMS      = 13'b0000000001000,
		S_TOT       = 13'b0000000010000,
		S_FRAC_GO   = 13'b0000000100000,
		S_FRAC_WAIT = 13'b0000001000000,
		S_DECIDE    = 13'b0000010000000,
		S_SL_GO     = 13'b0000100000000,
		S_SL_WAIT   = 13'b0001000000000,
		S_SL_UPD    = 13'b0010000000000,
		S_FINAL     = 13'b0100000000000,
		S_DONE      = 13'b1000000000000
	} state_t;

	// Divider command
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: design/sight_line_occlusion_step.sv
// A start item goes through S_START to its result; a line item goes straight to S_DONE when sight is
// already blocked, else through the multiplier steps, adding the fraction divide and up to two
// slope divides when it crosses. One item at a time; the shared 17x17 multiplier and
// the 32-step restoring divider are used in turn.
// Reset clears query state to zero and empties the output register.
`default_nettype none
module sight_line_occlusion_step
	import slo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_item,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_item
);

	state_t state_q;
	in_t    item_q;

	logic signed [15:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [31:0] eye_z_q, top_q, bot_q;
	logic               blocked_q, crossed_q;
	logic [2:0]         k_q;
	logic signed [33:0] prod_q [8];
	logic               s1_q, s2_q;
	logic signed [34:0] d1_q, d2_q;
	logic signed [35:0] tot_q;
	logic signed [31:0] lo_ceil_q, hi_floor_q;
	logic [14:0]        frac4_q;
	logic               sel_top_q, sl_neg_q;
	logic               out_valid_q;
	out_t               out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	slo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Whole-unit line vertices and sight deltas
	logic signed [16:0] lx1, ly1, lx2, ly2, sdx, sdy, nx, ny;
	assign lx1 = 17'($signed(item_q.x1[31:16]));
	assign ly1 = 17'($signed(item_q.y1[31:16]));
	assign lx2 = 17'($signed(item_q.x2[31:16]));
	assign ly2 = 17'($signed(item_q.y2[31:16]));
	assign sdx = 17'(ex_q) - 17'(sx_q);
	assign sdy = 17'(ey_q) - 17'(sy_q);
	assign nx  = ly1 - ly2;
	assign ny  = lx2 - lx1;

	// Select the operands of the shared multiplier
	logic signed [16:0] ma, mb;
	logic signed [33:0] mprod;
	always_comb begin
		case (k_q)
			3'd0: begin ma = ly1 - 17'(sy_q); mb = sdx; end
			3'd1: begin ma = lx1 - 17'(sx_q); mb = sdy; end
			3'd2: begin ma = ly2 - 17'(sy_q); mb = sdx; end
			3'd3: begin ma = lx2 - 17'(sx_q); mb = sdy; end
			3'd4: begin ma = lx1 - 17'(sx_q); mb = nx; end
			3'd5: begin ma = ly1 - 17'(sy_q); mb = ny; end
			3'd6: begin ma = lx1 - 17'(ex_q); mb = nx; end
			default: begin ma = ly1 - 17'(ey_q); mb = ny; end
		endcase
	end
	assign mprod = ma * mb;

	// Magnitudes and saturation test for the fraction
	logic [34:0] abs_d1;
	logic [35:0] abs_tot;
	logic        sat;
	assign abs_d1  = d1_q[34] ? 35'(-d1_q) : 35'(d1_q);
	assign abs_tot = tot_q[35] ? 36'(-tot_q) : 36'(tot_q);
	assign sat     = {15'd0, abs_d1[34:14]} >= abs_tot;

	// Slope dividend
	logic signed [31:0] dz, sh;
	logic [31:0]        abs_sh;
	assign dz     = sel_top_q ? (lo_ceil_q - eye_z_q) : (hi_floor_q - eye_z_q);
	assign sh     = {dz[25:0], 6'd0};
	assign abs_sh = sh[31] ? 32'(-sh) : 32'(sh);

	// Slope result
	logic [31:0]        q_sgn;
	logic signed [31:0] slope;
	assign q_sgn = sl_neg_q ? 32'(-div_rsp.quot) : div_rsp.quot;
	assign slope = {q_sgn[23:0], 8'd0};

	// Fraction window
	logic frac_ok;
	assign frac_ok = (d1_q[34] == tot_q[35]) && (div_rsp.quot >= FRAC_LOW)
		&& (div_rsp.quot <= FRAC_UNIT);

	// Drive the divider
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {1'b0, abs_d1, 16'd0};
		div_req.divisor  = abs_tot;
		if (state_q == S_FRAC_GO) begin
			div_req.start = (tot_q != '0) && !sat;
		end else if (state_q == S_SL_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = DVD_W'(abs_sh);
			div_req.divisor  = DVS_W'(frac4_q);
		end
	end

	logic in_acc, out_load;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer and query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sx_q      <= '0;
			sy_q      <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			eye_z_q   <= '0;
			top_q     <= '0;
			bot_q     <= '0;
			blocked_q <= 1'b0;
			crossed_q <= 1'b0;
			k_q       <= '0;
			sel_top_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						crossed_q <= 1'b0;
						k_q       <= '0;
						if (in_item.func == FUNC_START) begin
							sx_q      <= {in_item.x1[31:17], 1'b1};
							sy_q      <= {in_item.y1[31:17], 1'b1};
							ex_q      <= {in_item.x2[31:17], 1'b1};
							ey_q      <= {in_item.y2[31:17], 1'b1};
							eye_z_q   <= in_item.front_floor + in_item.front_ceiling
								- (in_item.front_ceiling >>> 2);
							blocked_q <= 1'b0;
							state_q   <= S_START;
						end else if (blocked_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_START: begin
					top_q   <= item_q.back_floor + item_q.back_ceiling - eye_z_q;
					bot_q   <= item_q.back_floor - eye_z_q;
					state_q <= S_DONE;
				end
				S_MUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7) state_q <= S_SUMS;
				end
				S_SUMS: state_q <= S_TOT;
				S_TOT: begin
					if (s1_q == s2_q) state_q <= S_DONE;
					else state_q <= S_FRAC_GO;
				end
				S_FRAC_GO: begin
					if (div_req.start) state_q <= S_FRAC_WAIT;
					else state_q <= S_DONE;
				end
				S_FRAC_WAIT: begin
					if (div_rsp.done) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!frac_ok) begin
						state_q <= S_DONE;
					end else begin
						crossed_q <= 1'b1;
						if (!item_q.two_sided) begin
							blocked_q <= 1'b1;
							state_q   <= S_DONE;
						end else if (item_q.front_floor == item_q.back_floor
							&& item_q.front_ceiling == item_q.back_ceiling) begin
							state_q <= S_DONE;
						end else if (lo_ceil_q <= hi_floor_q) begin
							blocked_q <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							sel_top_q <= (item_q.front_floor == item_q.back_floor);
							state_q   <= S_SL_GO;
						end
					end
				end
				S_SL_GO: state_q <= S_SL_WAIT;
				S_SL_WAIT: begin
					if (div_rsp.done) state_q <= S_SL_UPD;
				end
				S_SL_UPD: begin
					if (sel_top_q) begin
						if (slope < top_q) top_q <= slope;
						state_q <= S_FINAL;
					end else begin
						if (slope > bot_q) bot_q <= slope;
						if (item_q.front_ceiling != item_q.back_ceiling) begin
							sel_top_q <= 1'b1;
							state_q   <= S_SL_GO;
						end else begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (top_q <= bot_q) blocked_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) item_q <= in_item;
		if (state_q == S_MUL) prod_q[k_q] <= mprod;
		if (state_q == S_SUMS) begin
			s1_q       <= prod_q[0] > prod_q[1];
			s2_q       <= prod_q[2] > prod_q[3];
			d1_q       <= 35'(prod_q[4]) + 35'(prod_q[5]);
			d2_q       <= 35'(prod_q[6]) + 35'(prod_q[7]);
			lo_ceil_q  <= (item_q.front_ceiling < item_q.back_ceiling)
				? item_q.front_ceiling : item_q.back_ceiling;
			hi_floor_q <= (item_q.front_floor > item_q.back_floor)
				? item_q.front_floor : item_q.back_floor;
		end
		if (state_q == S_TOT) tot_q <= 36'(d1_q) - 36'(d2_q);
		if (state_q == S_DECIDE) frac4_q <= div_rsp.quot[16:2];
		if (state_q == S_SL_GO) sl_neg_q <= sh[31];
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.visible <= !blocked_q;
			out_q.crossed <= crossed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// File: design/slo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module slo_div
	import slo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [QUOT_W-1:0] dvd_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W:0]    trial;

	// Bring down the next dividend bit and trial-subtract
	assign shifted = {rem_q, dvd_q[QUOT_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// Control: count the iterations, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: upper dividend bits seed the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= DVS_W'(req.dividend[DVD_W-1:QUOT_W]);
			dvd_q  <= req.dividend[QUOT_W-1:0];
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QUOT_W-2:0], 1'b0};
			if (!trial[DVS_W]) begin
				rem_q  <= trial[DVS_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DVS_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire

// File: design/slo_checker.sv
// Port checker for the sight-line occlusion step, bound to the top level.
`default_nettype none
module slo_checker
	import slo_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire in_t  in_item,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_item
);

	// One item at a time: busy after each accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted item");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// A fresh result follows a busy cycle
	a_rise_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind sight_line_occlusion_step slo_checker u_slo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire

// File: dv/sight_line_occlusion_step_tb.sv
// Self-checking testbench for the sight-line occlusion step: directed and random queries.
`timescale 1ns / 100ps
`default_nettype none
module sight_line_occlusion_step_tb;
	import slo_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_item;
	logic out_valid;
	logic out_ready;
	out_t out_item;

	// Predictor state
	logic signed [15:0] p_sx, p_sy, p_ex, p_ey;
	logic signed [31:0] p_eye, p_top, p_bot;
	logic               p_blocked;

	out_t sight_expected[$];
	int   fail_count;
	bit   quiet;
	int   hold_cycles;

	sight_line_occlusion_step dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// Generate clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Limit the run
	initial begin
		#80000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic signed [15:0] snap_whole(logic [31:0] p);
		logic [31:0] s;
		s = (p & 32'hFFFE0000) | 32'h0001_0000;
		return s[31:16];
	endfunction

	function automatic logic signed [31:0] slope_from(logic signed [31:0] dz,
			longint frac);
		logic signed [31:0] sh, q;
		longint d;
		sh = dz <<< 6;
		d = frac / 4;
		q = 32'(longint'(sh) / d);
		return q <<< 8;
	endfunction

	// Compute the visibility after one item
	function automatic out_t predict_sight(in_t it);
		out_t r;
		longint ff, fc, bf, bc, lx1, ly1, lx2, ly2, sdx, sdy, nx, ny, d1, d2, tot, frac;
		longint ad1, atot, lo_ceil, hi_floor, q;
		logic signed [31:0] s, w;
		logic [15:0] h;
		bit s1, s2;
		ff = it.front_floor; fc = it.front_ceiling;
		bf = it.back_floor; bc = it.back_ceiling;
		r.crossed = 1'b0;
		if (it.func == FUNC_START) begin
			p_sx = snap_whole(it.x1); p_sy = snap_whole(it.y1);
			p_ex = snap_whole(it.x2); p_ey = snap_whole(it.y2);
			q = fc - (fc & 3);
			q = q / 4;
			p_eye = 32'(ff + fc - q);
			p_top = 32'(bf + bc - longint'(p_eye));
			p_bot = 32'(bf - longint'(p_eye));
			p_blocked = 1'b0;
			r.visible = 1'b1;
			return r;
		end
		if (!p_blocked) begin
			h = it.x1[31:16]; lx1 = $signed(h);
			h = it.y1[31:16]; ly1 = $signed(h);
			h = it.x2[31:16]; lx2 = $signed(h);
			h = it.y2[31:16]; ly2 = $signed(h);
			sdx = longint'(p_ex) - p_sx; sdy = longint'(p_ey) - p_sy;
			s1 = (ly1 - p_sy) * sdx > (lx1 - p_sx) * sdy;
			s2 = (ly2 - p_sy) * sdx > (lx2 - p_sx) * sdy;
			if (s1 != s2) begin
				nx = ly1 - ly2; ny = lx2 - lx1;
				d1 = (lx1 - p_sx) * nx + (ly1 - p_sy) * ny;
				d2 = (lx1 - p_ex) * nx + (ly1 - p_ey) * ny;
				tot = d1 - d2;
				if (tot != 0) begin
					ad1 = d1 < 0 ? -d1 : d1;
					atot = tot < 0 ? -tot : tot;
					if ((ad1 >>> 14) >= atot)
						frac = ((d1 < 0) != (tot < 0)) ? -64'sd2147483648 : 64'sd2147483647;
					else
						frac = (d1 * 65536) / tot;
					if (frac >= 4 && frac <= 65536) begin
						r.crossed = 1'b1;
						if (!it.two_sided) begin
							p_blocked = 1'b1;
						end else if (!(ff == bf && fc == bc)) begin
							lo_ceil = fc < bc ? fc : bc;
							hi_floor = ff > bf ? ff : bf;
							if (lo_ceil <= hi_floor) begin
								p_blocked = 1'b1;
							end else begin
								if (ff != bf) begin
									w = 32'(hi_floor - longint'(p_eye));
									s = slope_from(w, frac);
									if (s > p_bot) p_bot = s;
								end
								if (fc != bc) begin
									w = 32'(lo_ceil - longint'(p_eye));
									s = slope_from(w, frac);
									if (s < p_top) p_top = s;
								end
								if (p_top <= p_bot) p_blocked = 1'b1;
							end
						end
					end
				end
			end
		end
		r.visible = !p_blocked;
		return r;
	endfunction

	// Send one item, with an optional idle burst first
	task automatic send_item(in_t it);
		int gap;
		if (!quiet && ($urandom_range(0, 3) == 0)) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		sight_expected.push_back(predict_sight(it));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drive the receiver's stalls
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles = hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each accepted result
	initial begin
		out_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (sight_expected.size() == 0) begin
					$error("result with nothing expected: %b", out_item);
					fail_count++;
				end else begin
					e = sight_expected.pop_front();
					if (out_item.visible !== e.visible) begin
						$error("visible: expected %b actual %b", e.visible, out_item.visible);
						fail_count++;
					end
					if (out_item.crossed !== e.crossed) begin
						$error("crossed: expected %b actual %b", e.crossed, out_item.crossed);
						fail_count++;
					end
				end
			end
		end
	end

	function automatic logic [31:0] rnd_coord(int span);
		int v;
		v = $urandom_range(0, 2 * span) - span;
		return {16'(v), 16'($urandom)};
	endfunction

	function automatic logic [31:0] rnd_height();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return {16'($urandom_range(0, 8)), 16'h0};
			default: return ($urandom_range(0, 400) - 200) <<< 16;
		endcase
	endfunction

	function automatic in_t mk_start(int span);
		in_t it;
		it.func = FUNC_START;
		it.x1 = rnd_coord(span); it.y1 = rnd_coord(span);
		it.x2 = rnd_coord(span); it.y2 = rnd_coord(span);
		it.two_sided = $urandom_range(0, 1);
		it.front_floor = ($urandom_range(0, 40) - 20) <<< 16;
		it.front_ceiling = ($urandom_range(0, 80)) <<< 16 | 16'($urandom);
		it.back_floor = ($urandom_range(0, 40) - 20) <<< 16;
		it.back_ceiling = ($urandom_range(0, 80)) <<< 16;
		return it;
	endfunction

	function automatic in_t mk_line(int span);
		in_t it;
		it.func = FUNC_LINE;
		it.x1 = rnd_coord(span); it.y1 = rnd_coord(span);
		it.x2 = rnd_coord(span); it.y2 = rnd_coord(span);
		it.two_sided = ($urandom_range(0, 4) != 0);
		it.front_floor = rnd_height();
		it.front_ceiling = rnd_height();
		it.back_floor = $urandom_range(0, 3) == 0 ? it.front_floor : rnd_height();
		it.back_ceiling = $urandom_range(0, 3) == 0 ? it.front_ceiling : rnd_height();
		if ($urandom_range(0, 2) != 0) begin
			it.front_floor = ($urandom_range(0, 30) - 20) <<< 16;
			it.front_ceiling = ($urandom_range(40, 120)) <<< 16;
		end
		return it;
	endfunction

	// Directed: extremes, both operations, blocking and line-after-block
	task automatic test_directed();
		in_t it;
		it = mk_line(50);
		send_item(it);
		it = '0; it.func = FUNC_START;
		it.x2 = 32'sh0064_0000;
		it.back_ceiling = 32'sh0038_0000; it.front_ceiling = 32'sh0029_0000;
		send_item(it);
		// two-sided wall narrowing the window
		it = '0; it.func = FUNC_LINE; it.two_sided = 1'b1;
		it.x1 = 32'sh0032_0000; it.y1 = 32'shFFF6_0000;
		it.x2 = 32'sh0032_0000; it.y2 = 32'sh000A_0000;
		it.front_floor = 32'sh0000_0000; it.back_floor = 32'sh0010_0000;
		it.front_ceiling = 32'sh0080_0000; it.back_ceiling = 32'sh0040_0000;
		send_item(it);
		// identical sides, then closed gap
		it.back_floor = it.front_floor; it.back_ceiling = it.front_ceiling;
		send_item(it);
		it.back_ceiling = 32'shFFF0_0000;
		send_item(it);
		send_item(it);
		// one-sided wall
		it = '0; it.func = FUNC_START; it.x2 = 32'sh0064_0000;
		send_item(it);
		it = '0; it.func = FUNC_LINE;
		it.x1 = 32'sh0010_0000; it.y1 = 32'shFFFF_0000;
		it.x2 = 32'sh0010_0000; it.y2 = 32'sh0001_0000;
		send_item(it);
		// extreme fields
		it = '1; it.func = FUNC_START; send_item(it);
		it = '1; send_item(it);
		it = '0; it.func = FUNC_START;
		it.x1 = 32'sh8000_0000; it.y1 = 32'sh7FFF_FFFF;
		it.x2 = 32'sh7FFF_FFFF; it.y2 = 32'sh8000_0000;
		it.front_floor = 32'sh7FFF_FFFF; it.front_ceiling = 32'sh8000_0000;
		it.back_floor = 32'sh8000_0000; it.back_ceiling = 32'sh7FFF_FFFF;
		send_item(it);
		it.func = FUNC_LINE; it.two_sided = 1'b1;
		it.x1 = 32'sh8000_0000; it.y1 = 32'sh8000_0000;
		it.x2 = 32'sh7FFF_FFFF; it.y2 = 32'sh7FFF_FFFF;
		send_item(it);
		// line touching the looker: fraction below the window
		it = '0; it.func = FUNC_START; it.x2 = 32'sh7000_0000;
		send_item(it);
		it = '0; it.func = FUNC_LINE;
		it.x1 = 32'sh0001_0000; it.y1 = 32'shFFFF_0000;
		it.x2 = 32'sh0001_0000; it.y2 = 32'sh0001_0000;
		send_item(it);
	endtask

	// Random queries: mostly a start followed by a run of wall lines, with occasional starts among them
	task automatic test_random_queries(int n_items);
		int sent, nlines, span;
		sent = 0;
		while (sent < n_items) begin
			span = $urandom_range(0, 9) == 0 ? 32767 : 120;
			if ($urandom_range(0, 9) != 0) begin
				send_item(mk_start(span));
				sent++;
			end
			nlines = $urandom_range(1, 8);
			repeat (nlines) begin
				if ($urandom_range(0, 15) == 0) send_item(mk_start(span));
				else send_item(mk_line(span));
				sent++;
			end
		end
	endtask

	// Long receiver hold-off while items keep coming
	task automatic test_backpressure();
		hold_cycles = 600;
		test_random_queries(30);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (sight_expected.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (150) @(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		quiet = 1'b0;
		hold_cycles = 0;
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_queries(1600);
		quiet = 1'b1;
		test_random_queries(250);
		drain();
		if (fail_count == 0 && sight_expected.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
design/slo_pkg.sv
design/slo_div.sv
design/sight_line_occlusion_step.sv
design/slo_checker.sv
dv/sight_line_occlusion_step_tb.sv
